[hw/rtl/tcw_pkg.sv]
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);

   localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
   localparam logic [15:0]       CELLS_W16     = 16'(CELLS);

   // character and attribute codes
   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h0F;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [3:0] RESET_FG   = 4'd15;
   localparam logic [3:0] RESET_BG   = 4'd0;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG = 1'b0,
      CSR_BG = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK
   } state_type;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] chr;
   } cell_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      cell_type          wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_cmd_type;

   typedef struct packed {
      logic        valid;
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
      logic        scrolled;
   } result_type;

endpackage

[hw/rtl/tcw_ifs.sv]
interface tcw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  char_code;
   logic [10:0] cell_index;

   modport source (output valid, output req_type, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input req_type, input char_code, input cell_index,
                   output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_pos;
   logic [7:0]  cell_char;
   logic [7:0]  cell_attr;
   logic        scrolled;

   modport source (output valid, output cursor_pos, output cell_char, output cell_attr,
                   output scrolled, input ready);
   modport sink   (input valid, input cursor_pos, input cell_char, input cell_attr,
                   input scrolled, output ready);
endinterface

interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [3:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tcw_cell_ram.sv]
module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/tcw_ctrl.sv]
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   tcw_req_if.sink             req_chan,
   input  logic [7:0]          attr,
   input  logic                out_free,
   input  tcw_pkg::cell_type   rdata,
   output tcw_pkg::ram_cmd_type ram_cmd,
   output tcw_pkg::result_type result
);
   import tcw_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [ADDR_W-1:0] rowbase_ff, rowbase_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              scrolled_ff, scrolled_in;

   logic accept;
   logic is_nl;
   logic wrap;
   logic scroll_hit;
   logic idx_ok;

   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_chan.valid && req_chan.ready;
   assign is_nl      = (req_chan.char_code == CHAR_CR) || (req_chan.char_code == CHAR_LF);
   assign wrap       = is_nl || (col_ff == LAST_COL);
   assign scroll_hit = wrap && (row_ff == LAST_ROW);
   assign idx_ok     = 16'(req_chan.cell_index) < CELLS_W16;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (ptr_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.req_type)
                  REQ_WRITE: if (scroll_hit) state_in = ST_COPY;
                  REQ_READ:  if (idx_ok) state_in = ST_READ;
                  REQ_CLEAR: state_in = ST_BLANK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_COPY: begin
            if (ptr_ff == LAST_ROW_BASE) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (ptr_ff == LAST_CELL) state_in = ST_IDLE;
         end
         default:  state_in = ST_INIT;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ram_cmd     = '0;
      result      = '0;
      ptr_in      = ptr_ff;
      cursor_in   = cursor_ff;
      rowbase_in  = rowbase_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      scrolled_in = scrolled_ff;
      case (state_ff)
         ST_INIT: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = ptr_ff;
            ram_cmd.wdata = '{attr: RESET_ATTR, chr: BLANK_CHAR};
            ptr_in        = (ptr_ff == LAST_CELL) ? '0 : ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.req_type)
                  REQ_WRITE: begin
                     if (!is_nl) begin
                        ram_cmd.we    = 1'b1;
                        ram_cmd.waddr = cursor_ff;
                        ram_cmd.wdata = '{attr: attr, chr: req_chan.char_code};
                     end
                     if (scroll_hit) begin
                        cursor_in   = LAST_ROW_BASE;
                        rowbase_in  = LAST_ROW_BASE;
                        row_in      = LAST_ROW;
                        col_in      = '0;
                        scrolled_in = 1'b1;
                        ptr_in      = '0;
                     end else begin
                        if (wrap) begin
                           cursor_in  = rowbase_ff + ROW_STEP;
                           rowbase_in = rowbase_ff + ROW_STEP;
                           row_in     = row_ff + 1'b1;
                           col_in     = '0;
                        end else begin
                           cursor_in = cursor_ff + 1'b1;
                           col_in    = col_ff + 1'b1;
                        end
                        result.valid      = 1'b1;
                        result.cursor_pos = 11'(cursor_in);
                     end
                  end
                  REQ_READ: begin
                     if (idx_ok) begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = ADDR_W'(req_chan.cell_index);
                     end else begin
                        result.valid      = 1'b1;
                        result.cursor_pos = 11'(cursor_ff);
                     end
                  end
                  REQ_CLEAR: begin
                     cursor_in   = '0;
                     rowbase_in  = '0;
                     row_in      = '0;
                     col_in      = '0;
                     scrolled_in = 1'b0;
                     ptr_in      = '0;
                  end
                  default: begin
                     result.valid      = 1'b1;
                     result.cursor_pos = 11'(cursor_ff);
                  end
               endcase
            end
         end
         ST_READ: begin
            result.valid      = 1'b1;
            result.cursor_pos = 11'(cursor_ff);
            result.cell_char  = rdata.chr;
            result.cell_attr  = rdata.attr;
         end
         ST_COPY: begin
            // read runs one row and one cell ahead of the write; the write takes the registered RAM read word
            ram_cmd.re    = (ptr_ff != LAST_ROW_BASE);
            ram_cmd.raddr = ptr_ff + ROW_STEP;
            ram_cmd.we    = (ptr_ff != '0);
            ram_cmd.waddr = ptr_ff - 1'b1;
            ram_cmd.wdata = rdata;
            if (ptr_ff != LAST_ROW_BASE) ptr_in = ptr_ff + 1'b1;
         end
         ST_BLANK: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = ptr_ff;
            ram_cmd.wdata = '{attr: attr, chr: BLANK_CHAR};
            ptr_in        = ptr_ff + 1'b1;
            if (ptr_ff == LAST_CELL) begin
               ptr_in            = '0;
               result.valid      = 1'b1;
               result.cursor_pos = 11'(cursor_ff);
               result.scrolled   = scrolled_ff;
            end
         end
         default: begin
            ptr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         ptr_ff      <= '0;
         cursor_ff   <= '0;
         rowbase_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         cursor_ff   <= cursor_in;
         rowbase_ff  <= rowbase_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         scrolled_ff <= scrolled_in;
      end
   end

   // cursor stays the sum of its row base and column
   a_cursor_split: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == rowbase_ff + ADDR_W'(col_ff))
      else $error("cursor out of step with row/column");

   // scroll copy never writes at or past the row it is reading
   a_copy_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && ram_cmd.we && ram_cmd.re) |-> ram_cmd.waddr < ram_cmd.raddr)
      else $error("scroll copy overtook its read");

   // a cell read returns its word in the cycle after the request
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.req_type == REQ_READ && idx_ok) |=> result.valid)
      else $error("read result missing");

endmodule

[hw/rtl/text_console_writer.sv]
// Channel   Dir  Word contents                                  Accepted when
// req_chan  in   req_type, char_code, cell_index                valid && ready
// rsp_chan  out  cursor_pos, cell_char, cell_attr, scrolled     valid && ready
// csr_chan  in   index (0 fg_color, 1 bg_color), data[3:0]      valid && ready (ready tied high)
//
// Steps: a character or newline is answered in the cycle it is accepted; a cell read waits
// on the registered RAM read; a clear accepts, then writes one blank per cell; a scroll accepts,
// copies ROWS-1 rows up a cell a cycle through the registered RAM read, then blanks the last row.
// Reset: synchronous, then a clearing pass of one space per cell (white-on-black), ready low.
// Stalls: one word waits in the result register; a request is taken in the cycle that
// word leaves or when the register is empty. Exactly one result per request.
module text_console_writer (
   input  logic   clock,
   input  logic   reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan,
   tcw_csr_if.sink   csr_chan
);
   import tcw_pkg::*;

   // color registers
   logic [3:0] fg_ff, fg_in;
   logic [3:0] bg_ff, bg_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] cursor_pos_ff;
   logic [7:0]  cell_char_ff;
   logic [7:0]  cell_attr_ff;
   logic        scrolled_ff;

   logic        out_free;
   ram_cmd_type ram_cmd;
   result_type  result;
   cell_type    rdata;
   logic [15:0] rdata_raw;

   // config writes must arrive only while idle (the block does not enforce this), so no hazard against the sequencer
   assign csr_chan.ready = 1'b1;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FG:  fg_in = csr_chan.data;
            CSR_BG:  bg_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= RESET_FG;
         bg_ff <= RESET_BG;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // the register is free when empty or when its word leaves this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   tcw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .attr     ({bg_ff, fg_ff}),
      .out_free (out_free),
      .rdata    (rdata),
      .ram_cmd  (ram_cmd),
      .result   (result)
   );

   tcw_cell_ram #(
      .DEPTH  (CELLS),
      .WIDTH  (16),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (rdata_raw)
   );

   assign rdata = rdata_raw;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (result.valid) begin
         cursor_pos_ff <= result.cursor_pos;
         cell_char_ff  <= result.cell_char;
         cell_attr_ff  <= result.cell_attr;
         scrolled_ff   <= result.scrolled;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_pos = cursor_pos_ff;
   assign rsp_chan.cell_char  = cell_char_ff;
   assign rsp_chan.cell_attr  = cell_attr_ff;
   assign rsp_chan.scrolled   = scrolled_ff;

   // a new result never lands on a word that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_free)
      else $error("result register overwritten");

   // a produced result shows on the port in the next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> rsp_chan.valid)
      else $error("result not presented");

   // no request is taken while a result is still owed or waiting unread
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("request taken with result blocked");

endmodule
